// File: hdl/kslpd_pkg.sv
// ----------------------------------------------------------------------------
// kslpd_pkg
// Shared constants and types for the key short/long press detector.
// ----------------------------------------------------------------------------
package kslpd_pkg;

    localparam int NUM_KEYS = 2;

    localparam int OP_W      = 2;
    localparam int LEVEL_W   = 2;
    localparam int TIME_W    = 32;
    localparam int KEY_IDX_W = 4;
    localparam int MS_W      = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_POLL       = 2'd0;
    localparam logic [OP_W-1:0] OP_TAKE_CLICK = 2'd1;
    localparam logic [OP_W-1:0] OP_TAKE_HOLD  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS = 1'd1;

    localparam logic [MS_W-1:0] DEBOUNCE_MS_RESET   = 16'd50;
    localparam logic [MS_W-1:0] LONG_PRESS_MS_RESET = 16'd500;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_PRESSED = 2'd1;
    localparam logic [1:0] MODE_LONG    = 2'd2;

    typedef struct packed {
        logic poll;
        logic take_click;
        logic take_hold;
    } lane_ctrl_t;

    typedef struct packed {
        logic click;
        logic hold;
    } lane_flags_t;

endpackage

// File: hdl/kslpd_if.sv
// ----------------------------------------------------------------------------
// kslpd_in_if / kslpd_out_if
// Valid/ready channels carrying the request and result beats.
// ----------------------------------------------------------------------------
interface kslpd_in_if;
    import kslpd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [LEVEL_W-1:0]   key_levels;
    logic [TIME_W-1:0]    now_ms;
    logic [KEY_IDX_W-1:0] key_index;

    modport source (output valid, operation, key_levels, now_ms, key_index, input ready);
    modport sink (input valid, operation, key_levels, now_ms, key_index, output ready);
endinterface

interface kslpd_out_if;
    logic valid;
    logic ready;
    logic taken;

    modport source (output valid, taken, input ready);
    modport sink (input valid, taken, output ready);
endinterface

// File: hdl/kslpd_lane.sv
// ----------------------------------------------------------------------------
// kslpd_lane
// Per-key press state machine with press timestamp and sticky flags.
// ----------------------------------------------------------------------------
module kslpd_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kslpd_pkg::lane_ctrl_t         ctrl,
    input  logic                          released,
    input  logic [kslpd_pkg::TIME_W-1:0]  now_ms,
    input  logic [kslpd_pkg::MS_W-1:0]    debounce_ms,
    input  logic [kslpd_pkg::MS_W-1:0]    long_press_ms,
    output kslpd_pkg::lane_flags_t        flags
);
    import kslpd_pkg::*;

    logic [1:0]        mode_reg, mode_next;
    logic [TIME_W-1:0] press_time_reg, press_time_next;
    lane_flags_t       flags_reg, flags_next;
    logic [TIME_W-1:0] elapsed;
    logic              debounced;
    logic              long_held;

    assign elapsed   = now_ms - press_time_reg;
    assign debounced = elapsed >= {{(TIME_W-MS_W){1'b0}}, debounce_ms};
    assign long_held = elapsed >= {{(TIME_W-MS_W){1'b0}}, long_press_ms};

    always_comb
    begin
        mode_next        = mode_reg;
        press_time_next  = press_time_reg;
        flags_next.click = flags_reg.click & ~ctrl.take_click;
        flags_next.hold  = flags_reg.hold & ~ctrl.take_hold;
        if (ctrl.poll)
        begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    if (!released)
                    begin
                        press_time_next = now_ms;
                        mode_next       = MODE_PRESSED;
                    end
                end
                MODE_PRESSED:
                begin
                    if (debounced)
                    begin
                        if (released)
                        begin
                            flags_next.click = 1'b1;
                            mode_next        = MODE_IDLE;
                        end
                        else if (long_held)
                        begin
                            mode_next = MODE_LONG;
                        end
                    end
                end
                MODE_LONG:
                begin
                    if (released)
                    begin
                        flags_next.hold = 1'b1;
                        mode_next       = MODE_IDLE;
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            flags_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        press_time_reg <= press_time_next;
    end

    assign flags = flags_reg;

endmodule

// File: hdl/kslpd_merge.sv
// ----------------------------------------------------------------------------
// kslpd_merge
// Decodes the operation into lane strobes and merges the asked flag.
// ----------------------------------------------------------------------------
module kslpd_merge (
    input  logic                             fire,
    input  logic [kslpd_pkg::OP_W-1:0]       operation,
    input  logic [kslpd_pkg::KEY_IDX_W-1:0]  key_index,
    input  kslpd_pkg::lane_flags_t           flags [kslpd_pkg::NUM_KEYS],
    output kslpd_pkg::lane_ctrl_t            ctrl [kslpd_pkg::NUM_KEYS],
    output logic                             taken
);
    import kslpd_pkg::*;

    logic is_click;
    logic is_hold;
    logic hit;

    assign is_click = fire && (operation == OP_TAKE_CLICK);
    assign is_hold  = fire && (operation == OP_TAKE_HOLD);

    always_comb
    begin
        hit = 1'b0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            ctrl[k].poll       = fire && (operation == OP_POLL);
            ctrl[k].take_click = is_click && ({1'b0, key_index} == (KEY_IDX_W+1)'(k));
            ctrl[k].take_hold  = is_hold && ({1'b0, key_index} == (KEY_IDX_W+1)'(k));
            hit = hit | (ctrl[k].take_click & flags[k].click)
                      | (ctrl[k].take_hold & flags[k].hold);
        end
        taken = hit;
    end

endmodule

// File: hdl/key_short_long_press_detector.sv
// ----------------------------------------------------------------------------
// key_short_long_press_detector
// Debounced short and long press detection for a bank of active-low keys.
// ----------------------------------------------------------------------------
// Every request beat gives exactly one result beat. A poll beat updates all
// keys at once in parallel lanes, and a take beat reads and clears one key's
// click or hold flag. Each beat passes through the lanes into an output
// register, so a new beat is accepted every cycle as long as the result
// register is empty or being drained in the same cycle, and its result is
// valid in the cycle after the request is accepted. Configuration writes are expected only
// while the block is idle.
module key_short_long_press_detector (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [kslpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kslpd_pkg::MS_W-1:0]       cfg_data,
    kslpd_in_if.sink                         in_item,
    kslpd_out_if.source                      out_item
);
    import kslpd_pkg::*;

    logic [MS_W-1:0] debounce_ms_reg;
    logic [MS_W-1:0] long_press_ms_reg;
    logic            out_valid_reg, out_valid_next;
    logic            out_taken_reg, out_taken_next;
    logic            fire;
    logic            taken;
    lane_ctrl_t      ctrl  [NUM_KEYS];
    lane_flags_t     flags [NUM_KEYS];

    assign in_item.ready = !out_valid_reg || out_item.ready;
    assign fire          = in_item.valid && in_item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg   <= DEBOUNCE_MS_RESET;
            long_press_ms_reg <= LONG_PRESS_MS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DEBOUNCE_MS:   debounce_ms_reg   <= cfg_data;
                REG_LONG_PRESS_MS: long_press_ms_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        logic released;
        if (k < LEVEL_W)
        begin : g_level
            assign released = in_item.key_levels[k];
        end
        else
        begin : g_absent
            assign released = 1'b0;
        end

        kslpd_lane u_lane (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl[k]),
            .released      (released),
            .now_ms        (in_item.now_ms),
            .debounce_ms   (debounce_ms_reg),
            .long_press_ms (long_press_ms_reg),
            .flags         (flags[k])
        );
    end

    kslpd_merge u_merge (
        .fire      (fire),
        .operation (in_item.operation),
        .key_index (in_item.key_index),
        .flags     (flags),
        .ctrl      (ctrl),
        .taken     (taken)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_item.ready;
        out_taken_next = out_taken_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
            out_taken_next = taken;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_taken_reg <= out_taken_next;
    end

    assign out_item.valid = out_valid_reg;
    assign out_item.taken = out_taken_reg;

endmodule

// File: tb/kslpd_press_checker.sv
// ----------------------------------------------------------------------------
// kslpd_press_checker
// Watches the request, result and register write ports of the key press
// detector. It keeps its own copy of every key's mode, press time and sticky
// flags, works out the taken bit that each accepted request must give, and
// compares it with each accepted result beat in order.
// ----------------------------------------------------------------------------
module kslpd_press_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [kslpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kslpd_pkg::MS_W-1:0]      cfg_data,
    kslpd_in_if                             in_item,
    kslpd_out_if                            out_item,
    output int                              outstanding,
    output int                              errors,
    output int                              taken_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import kslpd_pkg::*;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [LEVEL_W-1:0]   key_levels;
        logic [TIME_W-1:0]    now_ms;
        logic [KEY_IDX_W-1:0] key_index;
    } request_t;

    logic [MS_W-1:0]   debounce_ms;
    logic [MS_W-1:0]   long_press_ms;
    logic [1:0]        mode_of_key [NUM_KEYS];
    logic [TIME_W-1:0] pressed_at [NUM_KEYS];
    logic              click_set [NUM_KEYS];
    logic              hold_set [NUM_KEYS];
    logic              taken_q [$];
    int                mismatch_count;
    int                result_count;
    int                set_count;

    function automatic logic predict_taken(request_t req);
        logic [TIME_W-1:0] elapsed;
        logic              released;
        logic              hit;
        hit = 1'b0;
        case (req.operation)
            OP_POLL:
                for (int k = 0; k < NUM_KEYS; k++)
                begin
                    released = (k < LEVEL_W) ? req.key_levels[k] : 1'b0;
                    elapsed  = req.now_ms - pressed_at[k];
                    case (mode_of_key[k])
                        MODE_IDLE:
                            if (!released)
                            begin
                                pressed_at[k]  = req.now_ms;
                                mode_of_key[k] = MODE_PRESSED;
                            end
                        MODE_PRESSED:
                            if (elapsed >= TIME_W'(debounce_ms))
                            begin
                                if (released)
                                begin
                                    click_set[k]   = 1'b1;
                                    mode_of_key[k] = MODE_IDLE;
                                end
                                else if (elapsed >= TIME_W'(long_press_ms))
                                begin
                                    mode_of_key[k] = MODE_LONG;
                                end
                            end
                        MODE_LONG:
                            if (released)
                            begin
                                hold_set[k]    = 1'b1;
                                mode_of_key[k] = MODE_IDLE;
                            end
                        default:
                            mode_of_key[k] = MODE_IDLE;
                    endcase
                end
            OP_TAKE_CLICK:
                if (req.key_index < NUM_KEYS && click_set[req.key_index])
                begin
                    click_set[req.key_index] = 1'b0;
                    hit = 1'b1;
                end
            OP_TAKE_HOLD:
                if (req.key_index < NUM_KEYS && hold_set[req.key_index])
                begin
                    hold_set[req.key_index] = 1'b0;
                    hit = 1'b1;
                end
            default:
                hit = 1'b0;
        endcase
        return hit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic     want;
        request_t req;
        if (!rst_n)
        begin
            debounce_ms   = DEBOUNCE_MS_RESET;
            long_press_ms = LONG_PRESS_MS_RESET;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                mode_of_key[k] = MODE_IDLE;
                pressed_at[k]  = '0;
                click_set[k]   = 1'b0;
                hold_set[k]    = 1'b0;
            end
            taken_q.delete();
            mismatch_count = 0;
            result_count   = 0;
            set_count      = 0;
            outstanding   <= 0;
            errors        <= 0;
            taken_seen    <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_DEBOUNCE_MS:   debounce_ms   = cfg_data;
                    REG_LONG_PRESS_MS: long_press_ms = cfg_data;
                    default: ;
                endcase
            end
            if (out_item.valid && out_item.ready)
            begin
                result_count++;
                if (out_item.taken === 1'b1)
                    set_count++;
                if (taken_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] result beat %0d arrived with nothing expected (taken=%0b)",
                                 $realtime, result_count, out_item.taken);
                end
                else
                begin
                    want = taken_q.pop_front();
                    if (out_item.taken !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("[%0t] result beat %0d: expected taken=%0b, got %0b",
                                     $realtime, result_count, want, out_item.taken);
                    end
                end
            end
            if (in_item.valid && in_item.ready)
            begin
                req.operation  = in_item.operation;
                req.key_levels = in_item.key_levels;
                req.now_ms     = in_item.now_ms;
                req.key_index  = in_item.key_index;
                taken_q.push_back(predict_taken(req));
            end
            outstanding <= taken_q.size();
            errors      <= mismatch_count;
            taken_seen  <= set_count;
        end
    end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the key short/long press detector. A directed
// opening walks through bounce rejection, clicks, long holds, release
// priority, time wrap and flag reads; then random key activity runs under
// several debounce and long-press settings with bursty requests and a
// stalling result side. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kslpd_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
    localparam int              STALL_LIMIT = 5000;
    localparam int              NUM_PHASES  = 9;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MS_W-1:0]      cfg_data;
    int                   outstanding;
    int                   errors;
    int                   taken_seen;
    int                   burst_left;
    int                   idle_cycles;
    int                   rx_cycle;
    int                   poll_count;
    int                   read_count;
    int                   other_count;
    int                   pause_count;

    logic [MS_W-1:0] phase_debounce [NUM_PHASES] =
        '{16'd0, 16'd65535, 16'd10, 16'd40, 16'd0, 16'd65535, 16'd50, 16'd3, 16'd200};
    logic [MS_W-1:0] phase_long [NUM_PHASES] =
        '{16'd0, 16'd65535, 16'd40, 16'd10, 16'd65535, 16'd0, 16'd500, 16'd7, 16'd1000};

    kslpd_in_if  in_item();
    kslpd_out_if out_item();

    key_short_long_press_detector DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .out_item  (out_item)
    );

    kslpd_press_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_item     (in_item),
        .out_item    (out_item),
        .outstanding (outstanding),
        .errors      (errors),
        .taken_seen  (taken_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (!rst_n)
            out_item.ready <= 1'b0;
        else
        begin
            case ((rx_cycle / 97) % 4)
                0:       out_item.ready <= 1'b1;
                1:       out_item.ready <= ($urandom_range(0, 1) == 1);
                2:       out_item.ready <= (rx_cycle % 4 != 0);
                default: out_item.ready <= ($urandom_range(0, 99) < 85);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_item.valid && in_item.ready) || (out_item.valid && out_item.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d cycles without a beat", idle_cycles);
            $display("key_short_long_press_detector verification failed");
            $finish;
        end
    end

    task automatic send_item(logic [OP_W-1:0] op, logic [LEVEL_W-1:0] levels,
                             logic [TIME_W-1:0] now, logic [KEY_IDX_W-1:0] idx);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                in_item.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_item.valid      <= 1'b1;
        in_item.operation  <= op;
        in_item.key_levels <= levels;
        in_item.now_ms     <= now;
        in_item.key_index  <= idx;
        @(posedge clk);
        while (!in_item.ready)
            @(posedge clk);
        case (op)
            OP_POLL:                    poll_count++;
            OP_TAKE_CLICK, OP_TAKE_HOLD: read_count++;
            default:                    other_count++;
        endcase
    endtask

    task automatic drain(int settle);
        in_item.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
        pause_count++;
    endtask

    task automatic set_timing(logic [MS_W-1:0] debounce, logic [MS_W-1:0] hold_time);
        cfg_write <= 1'b1;
        cfg_index <= REG_DEBOUNCE_MS;
        cfg_data  <= debounce;
        @(posedge clk);
        cfg_index <= REG_LONG_PRESS_MS;
        cfg_data  <= hold_time;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_keys(int count, logic [MS_W-1:0] debounce,
                            logic [MS_W-1:0] hold_time, bit near_wrap);
        logic [TIME_W-1:0]    now;
        logic [LEVEL_W-1:0]   levels;
        logic [OP_W-1:0]      op;
        logic [KEY_IDX_W-1:0] idx;
        int unsigned          span;
        int unsigned          pick;
        span = 32'((debounce > hold_time) ? debounce : hold_time);
        now = near_wrap ? (32'hFFFF_FFFF - $urandom_range(0, span * 3)) : $urandom;
        levels = '1;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 2)
                drain(0);
            pick = $urandom_range(0, 99);
            if (pick < 62)
            begin
                now = now + $urandom_range(0, span / 3 + 3);
                if ($urandom_range(0, 24) == 0)
                    now = $urandom;
                for (int k = 0; k < LEVEL_W; k++)
                    if ($urandom_range(0, 3) == 0)
                        levels[k] = ~levels[k];
                send_item(OP_POLL, levels, now, KEY_IDX_W'($urandom));
            end
            else if (pick < 94)
            begin
                op  = ($urandom_range(0, 1) == 1) ? OP_TAKE_HOLD : OP_TAKE_CLICK;
                idx = ($urandom_range(0, 6) == 0) ? KEY_IDX_W'($urandom_range(0, 15))
                                                  : KEY_IDX_W'($urandom_range(0, NUM_KEYS - 1));
                send_item(op, LEVEL_W'($urandom), $urandom, idx);
            end
            else
                send_item(OP_UNUSED, LEVEL_W'($urandom), $urandom, KEY_IDX_W'($urandom));
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        in_item.valid      = 1'b0;
        in_item.operation  = OP_POLL;
        in_item.key_levels = '1;
        in_item.now_ms     = '0;
        in_item.key_index  = '0;
        out_item.ready     = 1'b0;
        rx_cycle           = 0;
        idle_cycles        = 0;
        burst_left         = 0;
        poll_count         = 0;
        read_count         = 0;
        other_count        = 0;
        pause_count        = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty flags, unknown operation and out-of-range index at reset timing.
        send_item(OP_TAKE_CLICK, 2'b00, 32'hFFFF_FFFF, 4'd0);
        send_item(OP_TAKE_HOLD, 2'b11, 32'h0000_0000, 4'd1);
        send_item(OP_UNUSED, 2'b01, 32'hA5A5_5A5A, 4'd15);
        send_item(OP_TAKE_CLICK, 2'b10, 32'h5A5A_A5A5, 4'd15);
        // Bounce is ignored until the debounce time, then a release clicks.
        send_item(OP_POLL, 2'b10, 32'd100, 4'd0);
        send_item(OP_POLL, 2'b11, 32'd120, 4'd0);
        send_item(OP_POLL, 2'b11, 32'd150, 4'd0);
        send_item(OP_TAKE_CLICK, 2'b11, 32'd0, 4'd0);
        send_item(OP_TAKE_CLICK, 2'b11, 32'd0, 4'd0);
        // Long hold across the 32-bit time wrap.
        send_item(OP_POLL, 2'b01, 32'hFFFF_FF00, 4'd0);
        send_item(OP_POLL, 2'b00, 32'h0000_0200, 4'd0);
        send_item(OP_POLL, 2'b11, 32'h0000_0201, 4'd0);
        send_item(OP_POLL, 2'b11, 32'h0000_0300, 4'd0);
        send_item(OP_TAKE_HOLD, 2'b00, 32'd0, 4'd1);
        send_item(OP_TAKE_CLICK, 2'b00, 32'd0, 4'd0);
        send_item(OP_TAKE_HOLD, 2'b00, 32'd0, 4'd0);
        send_item(OP_TAKE_CLICK, 2'b00, 32'd0, 4'd1);
        // A release past the long-press time is a click, not a hold.
        send_item(OP_POLL, 2'b00, 32'd1000, 4'd0);
        send_item(OP_POLL, 2'b10, 32'd2000, 4'd0);
        send_item(OP_POLL, 2'b11, 32'd2001, 4'd0);
        send_item(OP_TAKE_CLICK, 2'b11, 32'd0, 4'd1);
        send_item(OP_TAKE_HOLD, 2'b11, 32'd0, 4'd1);
        send_item(OP_TAKE_HOLD, 2'b11, 32'd0, 4'd0);
        drain(4);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_timing(phase_debounce[p], phase_long[p]);
            run_keys(192, phase_debounce[p], phase_long[p], p % 2 == 1);
            drain(4);
        end

        $display("Ran %0d polls, %0d flag reads (%0d found set), %0d unused operations",
                 poll_count, read_count, taken_seen, other_count);
        $display("over %0d timing settings with %0d drained pauses.", NUM_PHASES + 1, pause_count);
        if (errors == 0)
            $display("key_short_long_press_detector verification clean");
        else
            $display("key_short_long_press_detector verification failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/kslpd_pkg.sv
hdl/kslpd_if.sv
hdl/kslpd_lane.sv
hdl/kslpd_merge.sv
hdl/key_short_long_press_detector.sv
tb/kslpd_press_checker.sv
tb/tb_top.sv
